// ----- sv/utt_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared item types, decode constants and the default queue depth.
// ----------------------------------------------------------------------------
package utt_pkg;

  // Depth of the queue between the decoder front and the unit emitter.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Byte classes.
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_CODE    = 8'h80;
  localparam logic [7:0] LEAD2_MASK   = 8'hE0;
  localparam logic [7:0] LEAD2_CODE   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK   = 8'hF0;
  localparam logic [7:0] LEAD3_CODE   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK   = 8'hF8;
  localparam logic [7:0] LEAD4_CODE   = 8'hF0;
  localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

  // Code point ranges.
  localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
  localparam logic [20:0] SURR_FIRST  = 21'h00D800;
  localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;

  // Surrogate halves.
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam logic [9:0]  TEN_BIT_MASK   = 10'h3FF;

  // One input byte.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_string;
  } in_item_t;

  // One UTF-16 result unit.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_of_run;
  } out_item_t;

  // One classified code point waiting for the emitter.
  typedef struct packed {
    logic        two_units;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } q_entry_t;

endpackage

// ----- sv/utt_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder front
// Tracks the pending sequence, finishes code points and classifies them
// into zero, one or two UTF-16 units for the queue.
// ----------------------------------------------------------------------------
module utt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  utt_pkg::in_item_t in_item_i,
  output logic              wr_en_o,
  output utt_pkg::q_entry_t wr_entry_o
);

  logic [1:0]  pend_q, pend_d;
  logic [20:0] acc_q, acc_d;
  logic [20:0] cp;
  logic [20:0] supp_off;
  logic        fin;
  logic        cont;
  logic        is_bmp;
  logic        is_surr;
  logic        is_supp;
  logic [7:0]  b;

  assign b = in_item_i.byte_value;

  // Sequence tracking: a continuation extends the accumulator, anything else
  // restarts decoding as a lead byte.
  always_comb begin
    pend_d = pend_q;
    acc_d  = acc_q;
    fin    = 1'b0;
    cp     = '0;
    cont   = (pend_q != 2'd0) && ((b & utt_pkg::CONT_MASK) == utt_pkg::CONT_CODE);
    if (cont) begin
      acc_d  = {acc_q[14:0], b[5:0]};
      pend_d = pend_q - 2'd1;
      if (pend_d == 2'd0) begin
        fin   = 1'b1;
        cp    = acc_d;
        acc_d = '0;
      end
    end else begin
      pend_d = 2'd0;
      acc_d  = '0;
      if (!b[7]) begin
        fin = 1'b1;
        cp  = {13'd0, b};
      end else if ((b & utt_pkg::LEAD2_MASK) == utt_pkg::LEAD2_CODE) begin
        acc_d  = {16'd0, b[4:0]};
        pend_d = 2'd1;
      end else if ((b & utt_pkg::LEAD3_MASK) == utt_pkg::LEAD3_CODE) begin
        acc_d  = {17'd0, b[3:0]};
        pend_d = 2'd2;
      end else if ((b & utt_pkg::LEAD4_MASK) == utt_pkg::LEAD4_CODE) begin
        acc_d  = {18'd0, b[2:0]};
        pend_d = 2'd3;
      end
    end
    if (in_item_i.end_of_string) begin
      pend_d = 2'd0;
      acc_d  = '0;
    end
  end

  // Decoder state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      acc_q  <= '0;
    end else if (in_valid_i) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

  // Classify the finished code point and form its units.
  always_comb begin
    is_bmp   = (cp <= utt_pkg::BMP_MAX);
    is_surr  = (cp >= utt_pkg::SURR_FIRST) && (cp <= utt_pkg::SURR_LAST);
    is_supp  = !is_bmp && (cp <= utt_pkg::CP_MAX);
    supp_off = cp - utt_pkg::SUPP_BASE;
    wr_entry_o.two_units = is_supp;
    wr_entry_o.unit0 = is_supp
      ? (utt_pkg::HIGH_SURR_BASE | {6'd0, supp_off[19:10] & utt_pkg::TEN_BIT_MASK})
      : cp[15:0];
    wr_entry_o.unit1 = utt_pkg::LOW_SURR_BASE | {6'd0, supp_off[9:0] & utt_pkg::TEN_BIT_MASK};
    wr_en_o = in_valid_i && fin && ((is_bmp && !is_surr) || is_supp);
  end

endmodule

// ----- sv/utt_queue.sv -----
// ----------------------------------------------------------------------------
// Classified code point queue
// Shifting queue: the oldest entry always sits in slot zero.
// ----------------------------------------------------------------------------
module utt_queue #(
  parameter int unsigned Depth = utt_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  utt_pkg::q_entry_t wr_entry_i,
  input  logic              rd_en_i,
  output utt_pkg::q_entry_t rd_entry_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  utt_pkg::q_entry_t slot_q [Depth];
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   wr_pos;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign rd_entry_o = slot_q[0];

  // A write in the same cycle as a read lands one slot lower.
  assign wr_pos = rd_en_i ? (cnt_q - CntW'(1)) : cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // On a read each slot below the top shifts down; the slot at the write position takes the new entry.
  for (genvar i = 0; i < Depth; i++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_pos == CntW'(i))) begin
        slot_q[i] <= wr_entry_i;
      end else if (rd_en_i) begin
        if (i < Depth - 1) begin
          slot_q[i] <= slot_q[(i < Depth - 1) ? i + 1 : i];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count exceeds depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(wr_en_i && !rd_en_i))
    else $error("write into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !empty_o)
    else $error("read from an empty queue");
`endif

endmodule

// ----- sv/utt_back.sv -----
// ----------------------------------------------------------------------------
// UTF-16 unit emitter
// Drains classified entries into an output register, one unit per transfer;
// the low surrogate of a pair waits in a side register.
// ----------------------------------------------------------------------------
module utt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  utt_pkg::q_entry_t  q_entry_i,
  output logic               q_rd_o,
  input  logic               pop_i,
  output logic               empty_o,
  output utt_pkg::out_item_t out_item_o
);

  logic               out_valid_q, out_valid_d;
  utt_pkg::out_item_t out_item_q, out_item_d;
  logic               second_q, second_d;
  logic [15:0]        low_unit_q, low_unit_d;
  logic               load;

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_item_q;

  // The output register refills whenever it is free or being taken.
  always_comb begin
    load        = !out_valid_q || pop_i;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    second_d    = second_q;
    low_unit_d  = low_unit_q;
    q_rd_o      = 1'b0;
    if (load) begin
      if (second_q) begin
        out_valid_d            = 1'b1;
        out_item_d.code_unit   = low_unit_q;
        out_item_d.last_of_run = 1'b1;
        second_d               = 1'b0;
      end else if (!q_empty_i) begin
        q_rd_o                 = 1'b1;
        out_valid_d            = 1'b1;
        out_item_d.code_unit   = q_entry_i.unit0;
        out_item_d.last_of_run = !q_entry_i.two_units;
        second_d               = q_entry_i.two_units;
        low_unit_d             = q_entry_i.unit1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    low_unit_q <= low_unit_d;
  end

`ifndef SYNTHESIS
  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> out_valid_q)
    else $error("low surrogate waiting without a high surrogate shown");
  a_pair_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_rd_o && q_entry_i.two_units) |=>
      (out_valid_q && second_q && !out_item_q.last_of_run))
    else $error("surrogate pair did not start with a high unit");
  a_pair_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (second_q && pop_i) |=> (out_valid_q && out_item_q.last_of_run && !second_q))
    else $error("low surrogate did not follow its high unit");
`endif

endmodule

// ----- sv/utf8_to_utf16_transcoder.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Decodes a UTF-8 byte stream and emits UTF-16 code units.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  input   | in        | push, full             | in_item_i  (byte, end of string)
//  result  | out       | pop, empty             | out_item_o (code unit, last of run)
//
//  One byte can be taken every cycle while the queue has room.
//  A result passes from the byte that finishes it through a queue slot and then
//  the output register when nothing waits ahead of it; the emitter gives one unit
//  per cycle while results are popped, and a surrogate pair gives two units.
//  Queue depth sets how long bytes keep flowing while results are not popped.
//  Reset clears the pending sequence, the queue and the output register.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
  parameter int unsigned QueueDepth = utt_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  utt_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output utt_pkg::out_item_t out_item_o
);

  logic              in_valid;
  logic              q_wr;
  logic              q_rd;
  logic              q_empty;
  utt_pkg::q_entry_t q_wr_entry;
  utt_pkg::q_entry_t q_rd_entry;

  // Input transfer.
  assign in_valid = push && !full;

  utt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_item_i  (in_item_i),
    .wr_en_o    (q_wr),
    .wr_entry_o (q_wr_entry)
  );

  utt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (q_wr),
    .wr_entry_i (q_wr_entry),
    .rd_en_i    (q_rd),
    .rd_entry_o (q_rd_entry),
    .full_o     (full),
    .empty_o    (q_empty)
  );

  utt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_entry_i  (q_rd_entry),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

// ----- sim/utt_unit_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-16 unit checker
// Watches both ports of the transcoder. Every byte transfer runs through
// a behavioral decoder that appends the code units it should produce. Every
// unit transfer is compared, field by field, with the oldest of those units.
// ----------------------------------------------------------------------------
module utt_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  utt_pkg::in_item_t  in_item_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  utt_pkg::out_item_t out_item_i,
  output int unsigned        units_waiting_o,
  output int unsigned        mismatches_o
);

  // Decoder state: continuation bytes still owed and the partial code point.
  logic [1:0]  conts_left;
  logic [20:0] code_point;

  // Units predicted but not yet seen on the result port, oldest first.
  utt_pkg::out_item_t expected_units[$];
  int unsigned        mismatch_count = 0;

  // Turns a finished code point into zero, one or two expected units.
  task automatic expect_code_point(input logic [20:0] cp);
    logic [20:0]        offset;
    utt_pkg::out_item_t unit;
    offset = cp - utt_pkg::SUPP_BASE;
    if (cp <= utt_pkg::BMP_MAX) begin
      // Lone surrogate values are dropped.
      if (cp < utt_pkg::SURR_FIRST || cp > utt_pkg::SURR_LAST) begin
        unit.code_unit   = cp[15:0];
        unit.last_of_run = 1'b1;
        expected_units   = {expected_units, unit};
      end
    end else if (cp <= utt_pkg::CP_MAX) begin
      unit.code_unit   = utt_pkg::HIGH_SURR_BASE | {6'd0, offset[19:10]};
      unit.last_of_run = 1'b0;
      expected_units   = {expected_units, unit};
      unit.code_unit   = utt_pkg::LOW_SURR_BASE | {6'd0, offset[9:0]};
      unit.last_of_run = 1'b1;
      expected_units   = {expected_units, unit};
    end
  endtask

  // Check result transfers first, then predict from the byte transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0]         data;
    utt_pkg::out_item_t oldest;
    if (!rst_ni) begin
      conts_left = '0;
      code_point = '0;
      expected_units.delete();
      units_waiting_o <= 0;
      mismatches_o    <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_units.size() == 0) begin
          $display("%0t: unit %h (last %b) arrived with nothing expected",
                   $time, out_item_i.code_unit, out_item_i.last_of_run);
          mismatch_count++;
        end else begin
          oldest = expected_units.pop_front();
          if (out_item_i.code_unit !== oldest.code_unit) begin
            $display("%0t: code_unit expected %h, got %h",
                     $time, oldest.code_unit, out_item_i.code_unit);
            mismatch_count++;
          end
          if (out_item_i.last_of_run !== oldest.last_of_run) begin
            $display("%0t: last_of_run expected %b, got %b",
                     $time, oldest.last_of_run, out_item_i.last_of_run);
            mismatch_count++;
          end
        end
      end

      if (push_i && !full_i) begin
        data = in_item_i.byte_value;
        if (conts_left != 2'd0 && (data & utt_pkg::CONT_MASK) == utt_pkg::CONT_CODE) begin
          // Continuation byte: shift in six payload bits.
          code_point = {code_point[14:0], data[5:0]};
          conts_left = conts_left - 2'd1;
          if (conts_left == 2'd0) begin
            expect_code_point(code_point);
            code_point = '0;
          end
        end else begin
          // Idle or broken sequence: the byte is decoded as a lead.
          conts_left = '0;
          code_point = '0;
          if (!data[7]) begin
            expect_code_point({13'd0, data});
          end else if ((data & utt_pkg::LEAD2_MASK) == utt_pkg::LEAD2_CODE) begin
            code_point = {16'd0, data[4:0]};
            conts_left = 2'd1;
          end else if ((data & utt_pkg::LEAD3_MASK) == utt_pkg::LEAD3_CODE) begin
            code_point = {17'd0, data[3:0]};
            conts_left = 2'd2;
          end else if ((data & utt_pkg::LEAD4_MASK) == utt_pkg::LEAD4_CODE) begin
            code_point = {18'd0, data[2:0]};
            conts_left = 2'd3;
          end
        end
        // End of string throws away any unfinished sequence.
        if (in_item_i.end_of_string) begin
          conts_left = '0;
          code_point = '0;
        end
      end

      units_waiting_o <= expected_units.size();
      mismatches_o    <= mismatch_count;
    end
  end

endmodule

// ----- sim/utf8_to_utf16_transcoder_tb.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Feeds a short directed byte string, then random UTF-8 text with broken
// sequences, invalid bytes and string ends mixed in, under several idle and
// stall patterns and one long result hold-off. A checker module beside the
// transcoder predicts and compares every code unit.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_tb;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseBytes = 300;
  localparam int unsigned HoldCycles = 250;
  localparam int unsigned TailCycles = 8;

  // Directed string; bit 8 marks end of string.
  localparam logic [8:0] DirectedBytes [27] = '{
    9'h07F,                          // largest one-byte value
    9'h100,                          // zero byte closing a string
    9'h0DF, 9'h0BF,                  // largest two-byte value
    9'h0EF, 9'h0BF, 9'h0BF,          // largest BMP value
    9'h0F0, 9'h09F, 9'h098, 9'h080,  // surrogate pair
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // largest valid code point
    9'h0F4, 9'h090, 9'h080, 9'h080,  // just out of range, dropped
    9'h0ED, 9'h0A0, 9'h080,          // surrogate code point, dropped
    9'h0FF,                          // invalid lead byte
    9'h0E2, 9'h041,                  // broken sequence, then a letter
    9'h1E2,                          // lead cut off by end of string
    9'h082                           // stray continuation byte
  };

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic               empty;
  logic               pop;
  utt_pkg::in_item_t  in_item;
  utt_pkg::out_item_t out_item;

  int unsigned units_waiting;
  int unsigned mismatches;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned bytes_sent;
  int unsigned idle_cycles = 0;
  logic        hold_request;

  utf8_to_utf16_transcoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  utt_unit_checker unit_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .in_item_i       (in_item),
    .empty_i         (empty),
    .pop_i           (pop),
    .out_item_i      (out_item),
    .units_waiting_o (units_waiting),
    .mismatches_o    (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offers one byte after a random idle gap and returns on its transfer.
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{byte_value: value, end_of_string: last};
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  // Sends one character: mostly well-formed sequences, some broken or noise.
  task automatic send_random_char();
    int unsigned kind;
    int unsigned conts;
    logic [7:0]  lead;
    kind  = $urandom_range(99);
    conts = 0;
    if (kind < 20) begin
      lead = 8'($urandom_range(8'h7F));
    end else if (kind < 40) begin
      lead  = 8'hC0 | 8'($urandom_range(8'h1F));
      conts = 1;
    end else if (kind < 60) begin
      lead  = 8'hE0 | 8'($urandom_range(8'h0F));
      conts = 2;
    end else if (kind < 80) begin
      lead  = 8'hF0 | 8'($urandom_range(7));
      conts = 3;
    end else if (kind < 90) begin
      lead = 8'hC0 + 8'($urandom_range(8'h37));
    end else begin
      lead = 8'($urandom_range(255));
    end
    send_byte(lead, $urandom_range(31) == 0);
    for (int i = 0; i < conts; i++) begin
      send_byte(8'h80 | 8'($urandom_range(8'h3F)), $urandom_range(31) == 0);
    end
    // A broken sequence is cut by a byte that is not a continuation.
    if (kind >= 80 && kind < 90) begin
      send_byte(8'h40 | 8'($urandom_range(255)), $urandom_range(31) == 0);
    end
  endtask

  // Stops offering bytes and waits until every predicted unit has arrived.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (units_waiting != 0);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned target;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    target             = bytes_sent + PhaseBytes;
    while (bytes_sent < target) send_random_char();
    wait_drained();
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    pop       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence and verdict.
  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    push               = 1'b0;
    in_item            = '0;
    hold_request       = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    bytes_sent         = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DirectedBytes); i++) begin
      send_byte(DirectedBytes[i][7:0], DirectedBytes[i][8]);
    end
    wait_drained();

    run_phase(0, 0);
    run_phase(52, 0);
    run_phase(0, 52);
    run_phase(21, 21);

    // Hold results back while bytes keep coming so the queue fills up.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 1'b1;
    for (int n = 0; n < 60; n++) send_random_char();
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/utt_pkg.sv
sv/utt_front.sv
sv/utt_queue.sv
sv/utt_back.sv
sv/utf8_to_utf16_transcoder.sv
sim/utt_unit_checker.sv
sim/utf8_to_utf16_transcoder_tb.sv
